// ===== rtl/cape_pkg.sv =====
// Package for the capsule axis extreme points block: widths, register
// indexes, item structs and the saturation helper. No dependencies.
`default_nettype none
package cape_pkg;

  localparam int unsigned CW        = 32;  // coordinate width
  localparam int unsigned EW        = 49;  // cap centre width
  localparam int unsigned RW        = 31;  // register width
  localparam int unsigned SQ_STEPS  = 32;  // root digits of a 64-bit square sum
  localparam int unsigned DIV_STEPS = 63;  // quotient bits of the radius scaling

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [RW-1:0] RADIUS_RST = 31'd65536;
  localparam logic [RW-1:0] HEIGHT_RST = 31'd131072;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic signed [CW-1:0] up_x;
    logic signed [CW-1:0] up_y;
    logic signed [CW-1:0] up_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } cape_in_t;

  typedef struct packed {
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] min_z;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] max_y;
    logic signed [CW-1:0] max_z;
    logic                 zero_axis;
  } cape_out_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [2:0][EW-1:0] lo_end;
    logic [2:0][EW-1:0] hi_end;
    logic [2:0][CW-1:0] dir;
    logic [63:0]        sq;
    logic               zero;
  } cape_job_t;

  function automatic logic [CW-1:0] sat32(input logic signed [65:0] v);
    logic [CW-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cape_front.sv =====
// Front part: accepts items, forms cap centres, picks the ends and the
// squared axis length. Depends on cape_pkg.
`default_nettype none
module cape_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire cape_pkg::cape_in_t  in_item,
  output logic                     in_full,
  input  wire logic [30:0]         height,
  input  wire logic                q_full,
  output logic                     q_push,
  output cape_pkg::cape_job_t      q_item
);

  logic                 adv;
  logic signed [31:0]   cin [3];
  logic signed [31:0]   uin [3];
  logic signed [31:0]   din [3];
  logic signed [31:0]   hgt;

  logic                 v1_r;
  logic signed [63:0]   ph_r [3];
  logic signed [63:0]   pd_r [3];
  logic signed [63:0]   pq_r [3];
  logic signed [31:0]   c_r  [3];
  logic signed [31:0]   d_r  [3];

  logic                 v2_r;
  cape_pkg::cape_job_t  job_r;
  cape_pkg::cape_job_t  job_nxt;

  assign adv     = !q_full;
  assign in_full = q_full;
  assign q_push  = v2_r && adv;
  assign q_item  = job_r;
  assign hgt     = $signed({1'b0, height});

  always_comb begin
    cin[0] = in_item.center_x; cin[1] = in_item.center_y; cin[2] = in_item.center_z;
    uin[0] = in_item.up_x;     uin[1] = in_item.up_y;     uin[2] = in_item.up_z;
    din[0] = in_item.dir_x;    din[1] = in_item.dir_y;    din[2] = in_item.dir_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_push;
      v2_r <= v1_r;
    end
  end

  // Products: cap offset, dot term and square term per axis.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ph_r[i] <= hgt * uin[i];
        pd_r[i] <= uin[i] * din[i];
        pq_r[i] <= din[i] * din[i];
        c_r[i]  <= cin[i];
        d_r[i]  <= din[i];
      end
    end
  end

  always_comb begin
    logic signed [63:0] off;
    logic signed [48:0] o49;
    logic signed [48:0] c49;
    logic signed [48:0] top;
    logic signed [48:0] bot;
    logic signed [65:0] dot;
    logic               top_max;
    dot     = pd_r[0] + pd_r[1] + pd_r[2];
    top_max = !dot[65] && (dot != 66'sd0);
    job_nxt.sq   = pq_r[0] + pq_r[1] + pq_r[2];
    job_nxt.zero = (job_nxt.sq == 64'd0);
    for (int i = 0; i < 3; i++) begin
      off = (ph_r[i] + 64'sd65536) >>> 17;
      o49 = off[48:0];
      c49 = {{17{c_r[i][31]}}, c_r[i]};
      top = c49 + o49;
      bot = c49 - o49;
      job_nxt.hi_end[i] = top_max ? top : bot;
      job_nxt.lo_end[i] = top_max ? bot : top;
      job_nxt.dir[i]    = d_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cape_queue.sv =====
// Two-entry queue between the front and back parts.
// Depends on cape_pkg.
`default_nettype none
module cape_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire cape_pkg::cape_job_t  wr_item,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      empty,
  output cape_pkg::cape_job_t       rd_item
);

  cape_pkg::cape_job_t mem_r [2];
  logic [1:0]          cnt_r;
  logic                wp_r;
  logic                rp_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cape_back.sv =====
// Back part: pipelined square root, radius scaling division, offsets and
// saturation, then a two-entry result queue. Depends on cape_pkg.
`default_nettype none
module cape_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [30:0]          radius,
  input  wire logic                 q_empty,
  input  wire cape_pkg::cape_job_t  q_item,
  output logic                      q_pop,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output cape_pkg::cape_out_t       out_item
);

  typedef struct packed {
    logic [33:0]         rem;
    logic [31:0]         root;
    logic [63:0]         s;
    cape_pkg::cape_job_t job;
  } sq_st_t;

  typedef struct packed {
    logic [31:0]         len;
    logic [2:0][62:0]    nq;
    logic [2:0][32:0]    rem;
    cape_pkg::cape_job_t job;
  } dv_st_t;

  localparam int unsigned NSQ = cape_pkg::SQ_STEPS;
  localparam int unsigned NDV = cape_pkg::DIV_STEPS;

  logic   adv;
  logic   sv_r [NSQ+1];
  sq_st_t sq_r [NSQ+1];
  logic   dvv_r [NDV+1];
  dv_st_t dv_r  [NDV+1];

  cape_pkg::cape_out_t ofifo_r [2];
  cape_pkg::cape_out_t res;
  logic [1:0]          ocnt_r;
  logic                owp_r;
  logic                orp_r;
  logic                opush;
  logic                opop;

  assign adv   = (ocnt_r != 2'd2);
  assign q_pop = adv && !q_empty;

  // Square root: one root digit per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0].rem  <= '0;
      sq_r[0].root <= '0;
      sq_r[0].s    <= q_item.sq;
      sq_r[0].job  <= q_item;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [35:0] cur;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;
    assign cur   = {sq_r[k].rem, sq_r[k].s[63:62]};
    assign trial = {2'b00, sq_r[k].root, 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (adv) begin
        sv_r[k+1] <= sv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k+1].rem  <= ge ? diff[33:0] : cur[33:0];
        sq_r[k+1].root <= {sq_r[k].root[30:0], ge};
        sq_r[k+1].s    <= {sq_r[k].s[61:0], 2'b00};
        sq_r[k+1].job  <= sq_r[k].job;
      end
    end
  end

  // Numerator: |dir| * radius + len / 2, rounding half up.
  logic [31:0] len_c;
  assign len_c = sq_r[NSQ].job.zero ? 32'd1 : sq_r[NSQ].root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r[0] <= 1'b0;
    end else if (adv) begin
      dvv_r[0] <= sv_r[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0] neg;
    logic [31:0] mag;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg = 33'd0 - {sq_r[NSQ].job.dir[i][31], sq_r[NSQ].job.dir[i]};
        mag = sq_r[NSQ].job.dir[i][31] ? neg[31:0] : sq_r[NSQ].job.dir[i];
        dv_r[0].nq[i]  <= mag * radius + 63'(len_c >> 1);
        dv_r[0].rem[i] <= '0;
      end
      dv_r[0].len <= len_c;
      dv_r[0].job <= sq_r[NSQ].job;
    end
  end

  // Restoring division: one quotient bit per stage in each of three lanes.
  for (genvar k = 0; k < NDV; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dvv_r[k+1] <= dvv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      logic [33:0] cur;
      logic [33:0] diff;
      logic        ge;
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          cur  = {dv_r[k].rem[i], dv_r[k].nq[i][62]};
          diff = cur - {2'b00, dv_r[k].len};
          ge   = (cur >= {2'b00, dv_r[k].len});
          dv_r[k+1].rem[i] <= ge ? diff[32:0] : cur[32:0];
          dv_r[k+1].nq[i]  <= {dv_r[k].nq[i][61:0], ge};
        end
        dv_r[k+1].len <= dv_r[k].len;
        dv_r[k+1].job <= dv_r[k].job;
      end
    end
  end

  // Apply the signed offset and saturate.
  always_comb begin
    logic signed [65:0] qs;
    logic signed [65:0] n;
    logic signed [48:0] lo;
    logic signed [48:0] hi;
    logic [31:0]        mn [3];
    logic [31:0]        mx [3];
    for (int i = 0; i < 3; i++) begin
      qs = $signed({3'b000, dv_r[NDV].nq[i]});
      if (dv_r[NDV].job.zero) begin
        n = '0;
      end else if (dv_r[NDV].job.dir[i][31]) begin
        n = -qs;
      end else begin
        n = qs;
      end
      lo = $signed(dv_r[NDV].job.lo_end[i]);
      hi = $signed(dv_r[NDV].job.hi_end[i]);
      mn[i] = cape_pkg::sat32(lo - n);
      mx[i] = cape_pkg::sat32(hi + n);
    end
    res.min_x = mn[0]; res.min_y = mn[1]; res.min_z = mn[2];
    res.max_x = mx[0]; res.max_y = mx[1]; res.max_z = mx[2];
    res.zero_axis = dv_r[NDV].job.zero;
  end

  assign opush     = dvv_r[NDV] && adv;
  assign opop      = out_pop && !out_empty;
  assign out_empty = (ocnt_r == 2'd0);
  assign out_item  = ofifo_r[orp_r];

  always_ff @(posedge clk) begin
    if (opush) begin
      ofifo_r[owp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
    end else begin
      if (opush) owp_r <= !owp_r;
      if (opop)  orp_r <= !orp_r;
      if (opush && !opop) begin
        ocnt_r <= ocnt_r + 2'd1;
      end else if (opop && !opush) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/capsule_axis_extreme_points_top.sv =====
// Path from an accepted item to its result: two front stages, one queue
// slot, 33 square root stages, 64 division stages and the result queue.
// Throughput: one item per cycle while the result queue has room, set by
// the fully pipelined root and divider. Reset (rst_n low, synchronous)
// empties both queues and all stage valid bits, loads radius 1.0, height 2.0.
`default_nettype none
module capsule_axis_extreme_points_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire cape_pkg::cape_in_t   in_item,
  output logic                      in_full,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output cape_pkg::cape_out_t       out_item,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_idx,
  input  wire logic [30:0]          cfg_data
);

  // Configuration registers, written by the user only while the block is idle
  // (unchecked here), so the stages read them live without a copy per item.
  logic [30:0] radius_r;
  logic [30:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= cape_pkg::RADIUS_RST;
      height_r <= cape_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        cape_pkg::CFG_RADIUS: radius_r <= cfg_data;
        cape_pkg::CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front part stalls only when the queue between the parts is full;
  // the back part stalls only when its result queue is full. Each side
  // therefore keeps taking items while the other waits.
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  cape_pkg::cape_job_t q_wr;
  cape_pkg::cape_job_t q_rd;

  cape_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .height  (height_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_wr)
  );

  cape_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_rd)
  );

  cape_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .radius    (radius_r),
    .q_empty   (q_empty),
    .q_item    (q_rd),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== rtl/cape_chk.sv =====
// Port-level checker for the top level, bound to it below.
// Depends on cape_pkg.
`default_nettype none
module cape_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_full,
  input wire logic                out_empty,
  input wire logic                out_pop,
  input wire cape_pkg::cape_out_t out_item
);

  a_reset_state: assert property (@(posedge clk) $rose(rst_n) |-> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result item lost");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_item))
    else $error("waiting result item changed");

endmodule

bind capsule_axis_extreme_points_top cape_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);
`default_nettype wire
